FILE: rtl/pedf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pedf_pkg: shared types and constants of the periodic EDF task dispatcher
// Slot count, field widths, register map and the per-slot status struct.
// ----------------------------------------------------------------------------
package pedf_pkg;

    // register file always holds this many slots
    localparam int SLOT_CAP         = 4;
    localparam int SLOT_W           = 2;

    localparam int NUM_SLOTS_DEF    = 4;
    localparam int TIME_BITS_DEF    = 32;
    localparam int PENDING_BITS_DEF = 4;

    localparam int PERIOD_BITS      = 16;
    localparam int PRIO_BITS        = 8;
    localparam int OUT_BITS         = 32;

    // register map, word index
    localparam int REG_IDX_BITS     = 3;
    localparam logic [REG_IDX_BITS-1:0] REG_PERIOD_BASE = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_PRIO_BASE   = 3'd4;
    localparam int APB_ADDR_BITS    = 5;
    localparam int APB_DATA_BITS    = 32;

    typedef struct packed {
        logic pending;   // slot has an instance waiting after this tick's release
        logic used;      // nonzero period
    } t_slot_stat;

endpackage : pedf_pkg
`default_nettype wire

FILE: rtl/pedf_slot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pedf_slot: one task slot of the dispatcher
// Holds the slot's next deadline and pending count, releases an instance when
// the deadline is reached and advances the deadline with saturation.
// ----------------------------------------------------------------------------
module pedf_slot #(
    parameter int TIME_BITS    = 32,
    parameter int PENDING_BITS = 4
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_step,
    input  wire logic                             i_take,
    input  wire logic [TIME_BITS-1:0]             i_now,
    input  wire logic [pedf_pkg::PERIOD_BITS-1:0] i_period,
    output logic      [TIME_BITS-1:0]             o_due,
    output pedf_pkg::t_slot_stat                  o_stat
);
    import pedf_pkg::*;

    localparam int SUM_W = TIME_BITS + 1;
    localparam logic [PENDING_BITS-1:0] PEND_MAX = {PENDING_BITS{1'b1}};

    logic [TIME_BITS-1:0]    r_due;
    logic [PENDING_BITS-1:0] r_pend;

    logic                    w_used;
    logic                    w_rel;
    logic [SUM_W-1:0]        w_sum;
    logic [TIME_BITS-1:0]    n_due;
    logic [PENDING_BITS-1:0] w_pend_rel;
    logic [PENDING_BITS-1:0] n_pend;

    always_comb begin
        w_used = (i_period != '0);
        w_rel  = w_used && (r_due <= i_now);
        w_sum  = {1'b0, r_due} + SUM_W'(i_period);
        n_due  = r_due;
        if (w_rel) begin
            // saturate at the largest time
            n_due = w_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : w_sum[TIME_BITS-1:0];
        end
        w_pend_rel = r_pend;
        if (w_rel && (r_pend != PEND_MAX)) begin
            w_pend_rel = r_pend + PENDING_BITS'(1);
        end
        n_pend = w_pend_rel;
        if (i_take) begin
            n_pend = w_pend_rel - PENDING_BITS'(1);
        end
    end

    assign o_due          = n_due;
    assign o_stat.pending = (w_pend_rel != '0);
    assign o_stat.used    = w_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_due  <= '0;
            r_pend <= '0;
        end else if (i_step) begin
            r_due  <= n_due;
            r_pend <= n_pend;
        end
    end

endmodule : pedf_slot
`default_nettype wire

FILE: rtl/periodic_edf_task_dispatcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// periodic_edf_task_dispatcher: earliest-deadline-first dispatcher for
// periodic task slots
//
// Each input item carries the current time. Every used slot (nonzero period)
// whose deadline has been reached gains one pending instance and its deadline
// advances by its period. The pending slot with the earliest deadline is then
// dispatched (ties: higher priority, then lower slot); with nothing pending the
// earliest deadline of the used slots is reported as the next wake time.
// Input and output channels use valid/stall; one result item per input item.
// An accepted item passes through the input register, then the release/select
// logic for all slots feeding the result register. One item is accepted per
// cycle while the receiver does not stall; the slot state update, a compare,
// saturating add and four-way deadline compare, sits between the two registers.
// While the receiver stalls, the result register holds and the input register
// fills; the input channel then stalls until the result is taken.
// Reset clears all deadlines, pending counts, periods and priorities, so every
// slot is due as soon as its period is written. The user writes periods and
// priorities over the APB port only while no item is in flight; not enforced.
// ----------------------------------------------------------------------------
module periodic_edf_task_dispatcher #(
    parameter int NUM_SLOTS    = pedf_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS    = pedf_pkg::TIME_BITS_DEF,
    parameter int PENDING_BITS = pedf_pkg::PENDING_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input channel
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [31:0]                        i_now_time,
    // output channel
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic                                    o_dispatched,
    output logic [pedf_pkg::SLOT_W-1:0]             o_task_slot,
    output logic [pedf_pkg::OUT_BITS-1:0]           o_task_deadline,
    output logic [pedf_pkg::OUT_BITS-1:0]           o_next_wake,
    // configuration
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pedf_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [pedf_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [pedf_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                    pready
);
    import pedf_pkg::*;

    localparam int EXT_W = (TIME_BITS > OUT_BITS) ? TIME_BITS : OUT_BITS;

    // configuration registers
    logic [PERIOD_BITS-1:0] r_period [SLOT_CAP];
    logic [PRIO_BITS-1:0]   r_prio   [SLOT_CAP];

    logic                    w_cfg_wr;
    logic [REG_IDX_BITS-1:0] w_reg_idx;
    logic [SLOT_W-1:0]       w_reg_slot;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready;
    assign w_reg_idx  = paddr[APB_ADDR_BITS-1:2];
    assign w_reg_slot = w_reg_idx[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOT_CAP; s++) begin
                r_period[s] <= '0;
                r_prio[s]   <= '0;
            end
        end else if (w_cfg_wr) begin
            if (w_reg_idx < REG_PRIO_BASE) begin
                r_period[w_reg_slot] <= pwdata[PERIOD_BITS-1:0];
            end else begin
                r_prio[w_reg_slot] <= pwdata[PRIO_BITS-1:0];
            end
        end
    end

    always_comb begin
        if (w_reg_idx < REG_PRIO_BASE) begin
            prdata = APB_DATA_BITS'(r_period[w_reg_slot]);
        end else begin
            prdata = APB_DATA_BITS'(r_prio[w_reg_slot]);
        end
    end

    // input register and stage control
    logic                 r_in_vld;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_out_vld;
    logic                 w_adv;
    logic                 w_in_acc;
    logic [EXT_W-1:0]     w_now_ext;

    assign w_adv     = r_in_vld && (!r_out_vld || !i_stall);
    assign o_stall   = r_in_vld && !w_adv;
    assign w_in_acc  = i_valid && !o_stall;
    assign w_now_ext = EXT_W'(i_now_time);
    assign o_valid   = r_out_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_now <= w_now_ext[TIME_BITS-1:0];
        end
    end

    // slots
    logic [TIME_BITS-1:0] w_due  [NUM_SLOTS];
    t_slot_stat           w_stat [NUM_SLOTS];
    logic                 w_best_vld;
    logic [SLOT_W-1:0]    w_best_idx;
    logic [TIME_BITS-1:0] w_best_due;
    logic [PRIO_BITS-1:0] w_best_prio;
    logic                 w_any_used;
    logic [TIME_BITS-1:0] w_wake;

    for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
        pedf_slot #(
            .TIME_BITS   (TIME_BITS),
            .PENDING_BITS(PENDING_BITS)
        ) u_slot (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_step  (w_adv),
            .i_take  (w_best_vld && (w_best_idx == SLOT_W'(g))),
            .i_now   (r_now),
            .i_period(r_period[g]),
            .o_due   (w_due[g]),
            .o_stat  (w_stat[g])
        );
    end

    // earliest deadline among pending slots, and among used slots for wake
    always_comb begin
        w_best_vld  = 1'b0;
        w_best_idx  = '0;
        w_best_due  = '0;
        w_best_prio = '0;
        w_any_used  = 1'b0;
        w_wake      = {TIME_BITS{1'b1}};
        for (int s = 0; s < NUM_SLOTS; s++) begin
            if (w_stat[s].pending &&
                (!w_best_vld || (w_due[s] < w_best_due) ||
                 ((w_due[s] == w_best_due) && (r_prio[s] > w_best_prio)))) begin
                w_best_vld  = 1'b1;
                w_best_idx  = SLOT_W'(s);
                w_best_due  = w_due[s];
                w_best_prio = r_prio[s];
            end
            if (w_stat[s].used && (!w_any_used || (w_due[s] < w_wake))) begin
                w_wake = w_due[s];
            end
            w_any_used = w_any_used || w_stat[s].used;
        end
    end

    // result register
    logic [EXT_W-1:0] w_due_ext;
    logic [EXT_W-1:0] w_wake_ext;

    assign w_due_ext  = EXT_W'(w_best_due);
    assign w_wake_ext = EXT_W'(w_wake);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_dispatched <= w_best_vld;
            if (w_best_vld) begin
                o_task_slot     <= w_best_idx;
                o_task_deadline <= w_due_ext[OUT_BITS-1:0];
                o_next_wake     <= '0;
            end else begin
                o_task_slot     <= '0;
                o_task_deadline <= '0;
                // no used slot: never wake
                o_next_wake     <= w_any_used ? w_wake_ext[OUT_BITS-1:0]
                                              : {OUT_BITS{1'b1}};
            end
        end
    end

    // checks
    a_disp_no_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && o_dispatched) |-> (o_next_wake == '0))
        else $error("dispatched result carries a wake time");

    a_idle_no_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !o_dispatched) |-> ((o_task_slot == '0) && (o_task_deadline == '0)))
        else $error("idle result carries a task");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> (r_in_vld && $stable(r_now)))
        else $error("held input item lost or overwritten");

endmodule : periodic_edf_task_dispatcher
`default_nettype wire

FILE: dv/periodic_edf_task_dispatcher_test.sv
// ----------------------------------------------------------------------------
// periodic_edf_task_dispatcher_test: self-checking bench for the EDF dispatcher
// Drives time ticks over the valid/stall input channel and programs periods and
// priorities over APB. A local model of the slot deadlines and pending counts
// predicts every result item. The checker compares it field by field, and the
// registers are read back. Directed items cover the special cases: no used
// slot, building counts, a period cleared with work pending and time running
// backwards. Random phases, a long receiver hold-off and a no-idle run at the
// largest time follow.
// ----------------------------------------------------------------------------
module periodic_edf_task_dispatcher_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pedf_pkg::*;

    typedef struct packed {
        logic                dispatched;
        logic [SLOT_W-1:0]   slot;
        logic [OUT_BITS-1:0] deadline;
        logic [OUT_BITS-1:0] wake;
    } t_dispatch;

    localparam int          IDLE_PCT    = 24;
    localparam int          HOLD_CYCLES = 300;
    localparam int          RAMP_ITEMS  = 30;
    localparam logic [31:0] T_MAX       = 32'hFFFF_FFFF;

    logic                     i_clk      = 1'b0;
    logic                     i_rst_n    = 1'b0;
    logic                     i_valid    = 1'b0;
    logic [31:0]              i_now_time = '0;
    logic                     i_stall    = 1'b0;
    logic                     psel       = 1'b0;
    logic                     penable    = 1'b0;
    logic                     pwrite     = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr      = '0;
    logic [APB_DATA_BITS-1:0] pwdata     = '0;

    logic                     o_stall;
    logic                     o_valid;
    logic                     o_dispatched;
    logic [SLOT_W-1:0]        o_task_slot;
    logic [OUT_BITS-1:0]      o_task_deadline;
    logic [OUT_BITS-1:0]      o_next_wake;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;

    // model state and register mirror
    logic [31:0]              due_ms   [SLOT_CAP];
    logic [PENDING_BITS_DEF-1:0] pend_cnt [SLOT_CAP];
    logic [PERIOD_BITS-1:0]   cfg_period [SLOT_CAP];
    logic [PRIO_BITS-1:0]     cfg_prio   [SLOT_CAP];

    t_dispatch                dispatch_q [$];
    t_dispatch                owed;
    logic [31:0]              now_ms     = '0;
    int                       mismatches = 0;
    bit                       quiet      = 1'b0;
    bit                       hold_req   = 1'b0;
    logic                     hold_on    = 1'b0;

    periodic_edf_task_dispatcher DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_now_time      (i_now_time),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_dispatched    (o_dispatched),
        .o_task_slot     (o_task_slot),
        .o_task_deadline (o_task_deadline),
        .o_next_wake     (o_next_wake),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        for (int s = 0; s < SLOT_CAP; s++) begin
            due_ms[s]     = '0;
            pend_cnt[s]   = '0;
            cfg_period[s] = '0;
            cfg_prio[s]   = '0;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at %0t ns: %s, got %h, want %h", $time, what, got, want);
        mismatches++;
    endtask

    // Release due slots, then pick the earliest deadline among pending slots.
    function automatic t_dispatch edf_next_dispatch(input logic [31:0] now);
        t_dispatch   r;
        int          best;
        logic [32:0] sum;
        logic        any_used;
        logic [31:0] wake;
        r        = '0;
        best     = -1;
        any_used = 1'b0;
        wake     = T_MAX;
        for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
            if (cfg_period[s] != 0 && due_ms[s] <= now) begin
                if (pend_cnt[s] != '1)
                    pend_cnt[s]++;
                sum       = {1'b0, due_ms[s]} + 33'(cfg_period[s]);
                due_ms[s] = sum[32] ? T_MAX : sum[31:0];
            end
        end
        for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
            if (pend_cnt[s] != 0 && (best < 0 || due_ms[s] < due_ms[best] ||
                (due_ms[s] == due_ms[best] && cfg_prio[s] > cfg_prio[best])))
                best = s;
        end
        if (best >= 0) begin
            pend_cnt[best]--;
            r.dispatched = 1'b1;
            r.slot       = SLOT_W'(best);
            r.deadline   = due_ms[best];
            return r;
        end
        for (int s = 0; s < NUM_SLOTS_DEF; s++) begin
            if (cfg_period[s] != 0) begin
                if (!any_used || due_ms[s] < wake)
                    wake = due_ms[s];
                any_used = 1'b1;
            end
        end
        r.wake = wake;
        return r;
    endfunction

    task automatic reg_write(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic reg_read(input logic [REG_IDX_BITS-1:0] idx, output logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        val = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        while (dispatch_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write all periods and priorities while idle, then read them back.
    task automatic load_slots(input logic [3:0][15:0] per, input logic [3:0][7:0] pri);
        logic [31:0] rd;
        logic [31:0] want;
        wait_idle();
        for (int s = 0; s < SLOT_CAP; s++) begin
            reg_write(REG_IDX_BITS'(REG_PERIOD_BASE + s), {16'h0, per[s]});
            cfg_period[s] = per[s];
        end
        for (int s = 0; s < SLOT_CAP; s++) begin
            reg_write(REG_IDX_BITS'(REG_PRIO_BASE + s), {24'h0, pri[s]});
            cfg_prio[s] = pri[s];
        end
        for (int r = 0; r < 2 * SLOT_CAP; r++) begin
            reg_read(REG_IDX_BITS'(r), rd);
            want = (r < SLOT_CAP) ? {16'h0, cfg_period[r]} : {24'h0, cfg_prio[r - SLOT_CAP]};
            if (rd !== want)
                report_mismatch($sformatf("register %0d read back", r), rd, want);
        end
    endtask

    // Offer one time tick; leave valid high once it is taken.
    task automatic send_item(input logic [31:0] t);
        if (!quiet) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid    <= 1'b1;
        i_now_time <= t;
        do @(posedge i_clk); while (o_stall);
        dispatch_q.push_back(edf_next_dispatch(t));
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (dispatch_q.size() == 0) begin
                report_mismatch("result item with nothing outstanding", o_next_wake, '0);
            end else begin
                owed = dispatch_q.pop_front();
                if (o_dispatched !== owed.dispatched)
                    report_mismatch("dispatched", 32'(o_dispatched), 32'(owed.dispatched));
                if (o_task_slot !== owed.slot)
                    report_mismatch("task_slot", 32'(o_task_slot), 32'(owed.slot));
                if (o_task_deadline !== owed.deadline)
                    report_mismatch("task_deadline", o_task_deadline, owed.deadline);
                if (o_next_wake !== owed.wake)
                    report_mismatch("next_wake", o_next_wake, owed.wake);
            end
        end
        i_stall <= hold_on || (!quiet && $urandom_range(99) < IDLE_PCT);
    end

    // receiver hold-off, counted here so the sender keeps running
    initial forever begin
        wait (hold_req);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_on  <= 1'b0;
        hold_req = 1'b0;
    end

    task automatic test_directed();
        // no slot used yet: never wake, also with time going backwards
        send_item('0);
        send_item(T_MAX);
        send_item(32'd7);
        i_valid <= 1'b0;
        // equal deadlines: priority first, then lowest slot
        load_slots({16'd5, 16'd5, 16'd5, 16'd5}, {8'd3, 8'd9, 8'd9, 8'd1});
        repeat (5) send_item('0);
        i_valid <= 1'b0;
        // four releases per tick against one dispatch: pending counts build up
        load_slots({16'd1, 16'd1, 16'd1, 16'd1}, {8'd0, 8'd255, 8'd0, 8'd255});
        repeat (7) send_item(32'd100);
        i_valid <= 1'b0;
        // periods cleared: pending instances still go out
        load_slots('0, {8'd0, 8'd255, 8'd0, 8'd255});
        repeat (3) send_item(32'd200);
        i_valid <= 1'b0;
        load_slots({16'd0, 16'd2, 16'd0, 16'hFFFF}, '0);
        send_item(32'd200);
        send_item(T_MAX);
        send_item(32'd201);
        send_item(32'd201);
        i_valid <= 1'b0;
    endtask

    task automatic test_backpressure();
        load_slots({16'd7, 16'd5, 16'd3, 16'd2}, {8'd10, 8'd20, 8'd30, 8'd40});
        now_ms   = 32'd1000;
        quiet    = 1'b1;
        hold_req = 1'b1;
        repeat (40) begin
            now_ms = now_ms + 32'd1;
            send_item(now_ms);
        end
        quiet = 1'b0;
        i_valid <= 1'b0;
    endtask

    task automatic test_random_settings(input int phase, input int n);
        logic [3:0][15:0] per;
        logic [3:0][7:0]  pri;
        int               pick;
        for (int s = 0; s < SLOT_CAP; s++) begin
            case ($urandom_range(9))
                0:       per[s] = '0;
                1:       per[s] = 16'hFFFF;
                2:       per[s] = 16'd1;
                3:       per[s] = 16'($urandom);
                default: per[s] = 16'($urandom_range(2, 40));
            endcase
            case ($urandom_range(5))
                0:       pri[s] = 8'd0;
                1:       pri[s] = 8'd255;
                2:       pri[s] = (s == 0) ? 8'd0 : pri[0];
                default: pri[s] = 8'($urandom);
            endcase
        end
        load_slots(per, pri);
        if (phase == 3)
            now_ms = $urandom;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 80)
                now_ms = now_ms + 32'($urandom_range(0, 12));
            else if (pick < 92)
                now_ms = now_ms + 32'($urandom_range(13, 3000));
            else if (pick < 97)
                now_ms = now_ms - 32'($urandom_range(1, 25));
            send_item(now_ms);
        end
        i_valid <= 1'b0;
    endtask

    // Offer the largest time and its neighbours back to back with no idling.
    task automatic test_largest_time();
        load_slots({16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, {8'd0, 8'd200, 8'd200, 8'd3});
        quiet = 1'b1;
        repeat (RAMP_ITEMS) send_item(T_MAX);
        repeat (3) send_item(T_MAX - 32'd1);
        repeat (2) send_item('0);
        repeat (2) send_item(T_MAX);
        quiet = 1'b0;
        i_valid <= 1'b0;
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_backpressure();
        for (int p = 0; p < 6; p++)
            test_random_settings(p, 110);
        test_largest_time();
        wait_idle();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("periodic_edf_task_dispatcher: match");
        else
            $display("periodic_edf_task_dispatcher: mismatch");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("periodic_edf_task_dispatcher: mismatch");
        $finish;
    end

endmodule : periodic_edf_task_dispatcher_test

FILE: files.f
rtl/pedf_pkg.sv
rtl/pedf_slot.sv
rtl/periodic_edf_task_dispatcher.sv
dv/periodic_edf_task_dispatcher_test.sv
